[rtl/vpa_pkg.sv]
package vpa_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int RW          = $clog2(MAX_RESULTS + 1);
	localparam logic [15:0] POOL_RESET = 16'd1000;
	localparam logic [31:0] TIME_MAX   = 32'hFFFF_FFFF;

	localparam logic       CMD_ARRIVE = 1'b0;
	localparam logic       CMD_TICK   = 1'b1;
	localparam logic       CFG_POLICY = 1'b0;
	localparam logic       CFG_POOL   = 1'b1;
	localparam logic [1:0] POL_BEST   = 2'd1;
	localparam logic [1:0] POL_WORST  = 2'd2;
	localparam logic       ST_PLACED  = 1'b0;
	localparam logic       ST_REJECT  = 1'b1;

	typedef struct packed {
		logic [15:0] size;
		logic [31:0] end_time;
		logic        free;
	} seg_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_REL,
		CELL_SHL,
		CELL_SHR,
		CELL_WR,
		CELL_CLR
	} cell_op_t;

endpackage

[rtl/vpa_cell.sv]
module vpa_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vpa_pkg::cell_op_t  op,
	input  vpa_pkg::seg_t      wdata,
	input  vpa_pkg::seg_t      left,
	input  vpa_pkg::seg_t      right,
	input  logic [31:0]        time_now,
	output vpa_pkg::seg_t      seg
);
	import vpa_pkg::*;

	seg_t seg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q.size     <= HEAD ? POOL_RESET : 16'd0;
			seg_q.end_time <= '0;
			seg_q.free     <= HEAD;
		end else begin
			case (op)
				CELL_REL: begin
					if (!seg_q.free && seg_q.end_time <= time_now)
						seg_q.free <= 1'b1;
				end
				CELL_SHL: seg_q <= right;
				CELL_SHR: seg_q <= left;
				CELL_WR:  seg_q <= wdata;
				CELL_CLR: seg_q <= '0;
				default:  seg_q <= seg_q;
			endcase
		end
	end

	assign seg = seg_q;

endmodule

[rtl/variable_partition_allocator_core.sv]
// Variable-partition memory allocator.
// Input words on s_axis: tuser is the command (arrive or tick), tdata carries
// req_size, run_time and tag. An arrive queues a request, or, with the queue
// full, returns one reject word. A tick frees expired segments, merges free
// neighbors, then places queued requests in order by the fit policy; each
// placement comes out on m_axis with its start address, tlast on the final one.
// The segment table is a row of cells that shift toward either neighbor, so a
// split or removal moves the whole tail at once. One item is handled at a time.
// A tick runs a release step and a merge pass, then per queued request a select
// step, a scan of the table and, if a hole fits, a placement and an emit step;
// a closing flush step ends it.
// Results leave through one output register plus one pending register; a
// stalled receiver holds the tick until its words drain, without loss.
// Configuration (fit_policy, pool_size) is written through cfg_we while idle;
// writing pool_size resets the table to one free segment (none for zero).
// Reset: pool 1000 units in one free segment, empty queue, time zero.
module variable_partition_allocator_core #(
	parameter int MAX_SEGMENTS = 32,
	parameter int QUEUE_DEPTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // req_size[15:0], run_time[31:16], tag[39:32]
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // result_tag[7:0], address[23:8], status[24]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);
	import vpa_pkg::*;

	localparam int IW  = $clog2(MAX_SEGMENTS);
	localparam int CW  = $clog2(MAX_SEGMENTS + 1);
	localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QW  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_REJ   = 9'b000000010,
		S_REL   = 9'b000000100,
		S_MERGE = 9'b000001000,
		S_QSEL  = 9'b000010000,
		S_SCAN  = 9'b000100000,
		S_PLACE = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_FLUSH = 9'b100000000
	} state_t;

	state_t state_q;

	logic [1:0]  policy_q;
	logic [31:0] time_q;
	logic [CW-1:0] count_q, p_q;
	logic [IW-1:0] pick_q;
	logic          pick_v_q;
	logic [15:0]   best_q, acc_q, paddr_q;
	logic [QW-1:0] qcount_q, qi_q;
	logic [RW-1:0] n_q;

	logic [15:0] qsize_q [QUEUE_DEPTH];
	logic [15:0] qrun_q  [QUEUE_DEPTH];
	logic [7:0]  qtag_q  [QUEUE_DEPTH];

	logic [7:0]  rej_tag_q, new_tag_q, pend_tag_q, out_tag_q;
	logic [15:0] new_addr_q, pend_addr_q, out_addr_q;
	logic        pend_v_q, out_v_q, out_status_q, out_last_q;

	seg_t     cur [MAX_SEGMENTS];
	seg_t     wd  [MAX_SEGMENTS];
	cell_op_t ops [MAX_SEGMENTS];

	genvar g;
	generate
		for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
			vpa_cell #(.HEAD(g == 0)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.op      (ops[g]),
				.wdata   (wd[g]),
				.left    ((g == 0) ? seg_t'('0) : cur[(g == 0) ? 0 : g - 1]),
				.right   ((g == MAX_SEGMENTS - 1) ? seg_t'('0)
				          : cur[(g == MAX_SEGMENTS - 1) ? g : g + 1]),
				.time_now(time_q),
				.seg     (cur[g])
			);
		end
	endgenerate

	logic [QIW-1:0] qidx;
	logic [15:0]    need, need_run;
	logic [32:0]    end_sum;
	logic [31:0]    end_t;
	seg_t           cp, cpm, cj, cpk;
	logic           drop, mrg, fits, better, split, out_free, out_load;
	logic [CW-1:0]  p_m1;

	assign qidx     = qi_q[QIW-1:0];
	assign need     = qsize_q[qidx];
	assign need_run = qrun_q[qidx];
	assign end_sum  = {1'b0, time_q} + {17'd0, need_run};
	assign end_t    = end_sum[32] ? TIME_MAX : end_sum[31:0];
	assign p_m1     = p_q - CW'(1);
	assign cp       = cur[p_q[IW-1:0]];
	assign cpm      = cur[p_m1[IW-1:0]];
	assign drop     = cp.free && (cp.size == 16'd0);
	assign mrg      = (p_q != '0) && cp.free && cpm.free;
	assign cj       = cur[p_q[IW-1:0]];
	assign fits     = cj.free && (cj.size >= need);
	assign better   = !pick_v_q
	               || ((policy_q == POL_BEST) ? (cj.size < best_q)
	               :   (policy_q == POL_WORST) ? (cj.size > best_q) : 1'b1);
	assign cpk      = cur[pick_q];
	assign split    = cpk.size != need;
	assign out_free = !out_v_q || m_axis_tready;
	// a new word enters the output register this cycle
	assign out_load = out_free && ((state_q == S_REJ)
	               || (pend_v_q && (state_q == S_EMIT || state_q == S_FLUSH)));

	always_comb begin
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			ops[i] = CELL_HOLD;
			wd[i]  = '0;
		end
		if (state_q == S_IDLE && cfg_we && cfg_index == CFG_POOL) begin
			for (int i = 0; i < MAX_SEGMENTS; i++)
				ops[i] = CELL_CLR;
			if (cfg_wdata != 16'd0) begin
				ops[0] = CELL_WR;
				wd[0]  = '{size: cfg_wdata, end_time: 32'd0, free: 1'b1};
			end
		end else if (state_q == S_REL) begin
			for (int i = 0; i < MAX_SEGMENTS; i++)
				ops[i] = CELL_REL;
		end else if (state_q == S_MERGE && p_q < count_q && (drop || mrg)) begin
			for (int i = 0; i < MAX_SEGMENTS; i++)
				if (CW'(i) >= p_q)
					ops[i] = CELL_SHL;
			if (!drop) begin
				ops[p_m1[IW-1:0]] = CELL_WR;
				wd[p_m1[IW-1:0]]  = '{size: cpm.size + cp.size, end_time: cpm.end_time,
				                      free: 1'b1};
			end
		end else if (state_q == S_PLACE) begin
			if (split) begin
				for (int i = 0; i < MAX_SEGMENTS; i++)
					if (i > int'(pick_q) + 1)
						ops[i] = CELL_SHR;
				ops[pick_q + IW'(1)] = CELL_WR;
				wd[pick_q + IW'(1)]  = '{size: cpk.size - need, end_time: cpk.end_time,
				                        free: cpk.free};
			end
			ops[pick_q] = CELL_WR;
			wd[pick_q]  = '{size: need, end_time: end_t, free: 1'b0};
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid && s_axis_tuser == CMD_ARRIVE
		    && qcount_q < QW'(QUEUE_DEPTH)) begin
			qsize_q[qcount_q[QIW-1:0]] <= s_axis_tdata[15:0];
			qrun_q[qcount_q[QIW-1:0]]  <= s_axis_tdata[31:16];
			qtag_q[qcount_q[QIW-1:0]]  <= s_axis_tdata[39:32];
		end else if (state_q == S_EMIT && (!pend_v_q || out_free)) begin
			for (int k = 0; k < QUEUE_DEPTH - 1; k++)
				if (QW'(k) >= qi_q) begin
					qsize_q[k] <= qsize_q[k + 1];
					qrun_q[k]  <= qrun_q[k + 1];
					qtag_q[k]  <= qtag_q[k + 1];
				end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= 2'd0;
			time_q       <= '0;
			count_q      <= CW'(1);
			qcount_q     <= '0;
			p_q          <= '0;
			qi_q         <= '0;
			n_q          <= '0;
			pick_q       <= '0;
			pick_v_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
			best_q       <= '0;
			acc_q        <= '0;
			paddr_q      <= '0;
			rej_tag_q    <= '0;
			new_tag_q    <= '0;
			new_addr_q   <= '0;
			pend_tag_q   <= '0;
			pend_addr_q  <= '0;
			out_tag_q    <= '0;
			out_addr_q   <= '0;
			out_status_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready && !out_load)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == CFG_POLICY)
							policy_q <= cfg_wdata[1:0];
						else
							count_q <= (cfg_wdata != 16'd0) ? CW'(1) : '0;
					end
					if (s_axis_tvalid) begin
						if (s_axis_tuser == CMD_TICK) begin
							state_q <= S_REL;
						end else if (qcount_q >= QW'(QUEUE_DEPTH)) begin
							rej_tag_q <= s_axis_tdata[39:32];
							state_q   <= S_REJ;
						end else begin
							qcount_q <= qcount_q + QW'(1);
						end
					end
				end
				S_REJ: begin
					if (out_free) begin
						out_v_q      <= 1'b1;
						out_tag_q    <= rej_tag_q;
						out_addr_q   <= '0;
						out_status_q <= ST_REJECT;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_REL: begin
					p_q     <= '0;
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (p_q >= count_q) begin
						qi_q    <= '0;
						n_q     <= '0;
						state_q <= S_QSEL;
					end else if (drop || mrg) begin
						count_q <= count_q - CW'(1);
					end else begin
						p_q <= p_q + CW'(1);
					end
				end
				S_QSEL: begin
					if (qi_q >= qcount_q || n_q == RW'(MAX_RESULTS)) begin
						state_q <= S_FLUSH;
					end else if (count_q >= CW'(MAX_SEGMENTS)) begin
						qi_q <= qi_q + QW'(1);
					end else begin
						p_q      <= '0;
						acc_q    <= '0;
						pick_v_q <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (p_q >= count_q) begin
						if (pick_v_q) begin
							state_q <= S_PLACE;
						end else begin
							qi_q    <= qi_q + QW'(1);
							state_q <= S_QSEL;
						end
					end else begin
						acc_q <= acc_q + cj.size;
						p_q   <= p_q + CW'(1);
						if (fits && better) begin
							pick_v_q <= 1'b1;
							pick_q   <= p_q[IW-1:0];
							best_q   <= cj.size;
							paddr_q  <= acc_q;
							// first fit (any policy but best or worst) stops at the first hole that fits
							if (policy_q != POL_BEST && policy_q != POL_WORST)
								state_q <= S_PLACE;
						end
					end
				end
				S_PLACE: begin
					if (split)
						count_q <= count_q + CW'(1);
					new_tag_q  <= qtag_q[qidx];
					new_addr_q <= paddr_q;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q      <= 1'b1;
							out_tag_q    <= pend_tag_q;
							out_addr_q   <= pend_addr_q;
							out_status_q <= ST_PLACED;
							out_last_q   <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_tag_q  <= new_tag_q;
						pend_addr_q <= new_addr_q;
						qcount_q    <= qcount_q - QW'(1);
						n_q         <= n_q + RW'(1);
						state_q     <= S_QSEL;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q      <= 1'b1;
							out_tag_q    <= pend_tag_q;
							out_addr_q   <= pend_addr_q;
							out_status_q <= ST_PLACED;
							out_last_q   <= 1'b1;
						end
						pend_v_q <= 1'b0;
						if (time_q != TIME_MAX)
							time_q <= time_q + 32'd1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_status_q, out_addr_q, out_tag_q};
	assign m_axis_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS)) else $error("segment count overflow");
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= QW'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q) else $error("pending word left after tick");
	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> (count_q < CW'(MAX_SEGMENTS)))
		else $error("placement into full table");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import vpa_pkg::*;

	localparam int          SEGS       = 32;
	localparam int          QDEPTH     = 16;
	localparam int          DRAIN_WAIT = 800;
	localparam logic [1:0]  POL_FIRST  = 2'd0;
	localparam logic [1:0]  POL_ODD    = 2'd3;

	typedef struct {
		logic [7:0]  tag;
		logic [15:0] addr;
		logic        status;
		logic        last;
	} alloc_word_t;

	class alloc_scoreboard;
		logic [15:0] seg_sz[SEGS];
		logic [31:0] seg_end[SEGS];
		logic        seg_fr[SEGS];
		int          nseg;
		logic [15:0] rq_size[QDEPTH];
		logic [15:0] rq_run[QDEPTH];
		logic [7:0]  rq_tag[QDEPTH];
		int          nreq;
		logic [31:0] now;
		logic [1:0]  policy;
		logic [15:0] pool;
		alloc_word_t pending[$];
		int          errors, placed, rejected, ticks;

		function void table_init();
			for (int i = 0; i < SEGS; i++) begin
				seg_sz[i] = 0; seg_end[i] = 0; seg_fr[i] = 0;
			end
			nseg = 0;
			if (pool != 0) begin
				seg_sz[0] = pool; seg_fr[0] = 1; nseg = 1;
			end
		endfunction

		function void reset_state();
			policy = POL_FIRST; pool = POOL_RESET;
			nreq = 0; now = 0;
			errors = 0; placed = 0; rejected = 0; ticks = 0;
			table_init();
		endfunction

		function void write_reg(logic idx, logic [15:0] val);
			if (idx == CFG_POLICY) policy = val[1:0];
			else begin
				pool = val;
				table_init();
			end
		endfunction

		function void free_and_merge();
			int k;
			k = 0;
			for (int i = 0; i < nseg; i++)
				if (!seg_fr[i] && seg_end[i] <= now) seg_fr[i] = 1;
			for (int i = 0; i < nseg; i++) begin
				if (seg_fr[i]) begin
					if (seg_sz[i] == 0) continue;
					if (k > 0 && seg_fr[k-1]) begin
						seg_sz[k-1] += seg_sz[i];
						continue;
					end
				end
				seg_sz[k] = seg_sz[i]; seg_end[k] = seg_end[i]; seg_fr[k] = seg_fr[i];
				k++;
			end
			for (int i = k; i < SEGS; i++) begin
				seg_sz[i] = 0; seg_end[i] = 0; seg_fr[i] = 0;
			end
			nseg = k;
		endfunction

		function int pick_hole(logic [15:0] need);
			int pick;
			logic [15:0] best;
			pick = -1; best = 0;
			if (nseg >= SEGS) return -1;
			for (int i = 0; i < nseg; i++) begin
				if (!seg_fr[i] || seg_sz[i] < need) continue;
				if (policy == POL_BEST) begin
					if (pick < 0 || seg_sz[i] < best) begin pick = i; best = seg_sz[i]; end
				end else if (policy == POL_WORST) begin
					if (pick < 0 || seg_sz[i] > best) begin pick = i; best = seg_sz[i]; end
				end else
					return i;
			end
			return pick;
		endfunction

		function logic [15:0] carve(int j, logic [15:0] need, logic [15:0] run);
			logic [15:0] addr;
			logic [32:0] sum;
			addr = 0;
			sum = {1'b0, now} + run;
			for (int k = 0; k < j; k++) addr += seg_sz[k];
			if (seg_sz[j] != need) begin
				for (int k = nseg; k > j; k--) begin
					seg_sz[k] = seg_sz[k-1]; seg_end[k] = seg_end[k-1]; seg_fr[k] = seg_fr[k-1];
				end
				nseg++;
				seg_sz[j+1] -= need;
			end
			seg_sz[j] = need;
			seg_end[j] = sum[32] ? TIME_MAX : sum[31:0];
			seg_fr[j] = 0;
			return addr;
		endfunction

		function void note_input(logic cmd, logic [15:0] size, logic [15:0] run,
			logic [7:0] tg);
			alloc_word_t w;
			int i, n, j;
			if (cmd == CMD_ARRIVE) begin
				if (nreq >= QDEPTH) begin
					w.tag = tg; w.addr = 0; w.status = ST_REJECT; w.last = 1;
					pending = {pending, w};
					return;
				end
				rq_size[nreq] = size; rq_run[nreq] = run; rq_tag[nreq] = tg;
				nreq++;
				return;
			end
			ticks++;
			free_and_merge();
			i = 0; n = 0;
			while (i < nreq && n < MAX_RESULTS) begin
				j = pick_hole(rq_size[i]);
				if (j < 0) begin
					i++;
					continue;
				end
				w.tag = rq_tag[i];
				w.addr = carve(j, rq_size[i], rq_run[i]);
				w.status = ST_PLACED; w.last = 0;
				pending = {pending, w};
				n++;
				for (int k = i; k + 1 < nreq; k++) begin
					rq_size[k] = rq_size[k+1]; rq_run[k] = rq_run[k+1]; rq_tag[k] = rq_tag[k+1];
				end
				nreq--;
			end
			if (n > 0) pending[pending.size()-1].last = 1;
			if (now != TIME_MAX) now++;
		endfunction

		function void check(logic [7:0] tg, logic [15:0] addr, logic st, logic lst);
			alloc_word_t w;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: tag %0d addr %0d st %0d", tg, addr, st);
				return;
			end
			w = pending.pop_front();
			if (st == ST_REJECT) rejected++; else placed++;
			if (w.tag !== tg || w.addr !== addr || w.status !== st || w.last !== lst) begin
				errors++;
				if (errors <= 10)
					$display("word mismatch: exp tag %0d addr %0d st %0d last %0d, got %0d %0d %0d %0d",
						w.tag, w.addr, w.status, w.last, tg, addr, st, lst);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [15:0] cfg_wdata = 0;

	alloc_scoreboard sb = new();
	bit idle_en = 1;
	int hold_req = 0;

	variable_partition_allocator_core dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// sink: checks accepted words and drives tready
	int stall_left = 0, hold_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check(m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[24], m_axis_tlast);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 0;
			end else if (idle_en && $urandom_range(5) == 0) begin
				stall_left = $urandom_range(3);
				m_axis_tready <= 0;
			end else
				m_axis_tready <= 1;
		end
	end

	task automatic send(logic cmd, logic [15:0] size, logic [15:0] run, logic [7:0] tg);
		if (idle_en && $urandom_range(4) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {tg, run, size};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(cmd, size, run, tg);
	endtask

	task automatic arrive(logic [15:0] size, logic [15:0] run);
		send(CMD_ARRIVE, size, run, 8'($urandom_range(255)));
	endtask

	task automatic tick();
		send(CMD_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// let everything drain, then wait out a tick that places nothing
	task automatic settle();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		settle();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic random_phase(int n, int pool_hint);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40) tick();
			else if (r < 85)
				arrive(16'($urandom_range(1, pool_hint / 3 + 1)), 16'($urandom_range(0, 12)));
			else if (r < 92) arrive(16'($urandom), 16'($urandom));
			else if (r < 95) arrive(16'd0, 16'($urandom_range(0, 5)));
			else arrive(16'($urandom_range(1, pool_hint)), 16'hFFFF);
		end
	endtask

	initial begin
		sb.reset_state();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// basics: extremes, zero-size and exact fit on the reset pool
		arrive(16'hFFFF, 16'd0);
		arrive(16'd0, 16'd0);
		arrive(16'd1000, 16'd1);
		tick();
		tick();
		tick();
		write_reg(CFG_POOL, 16'hFFFF);
		arrive(16'hFFFF, 16'hFFFF);
		tick();
		write_reg(CFG_POOL, 16'd1);
		arrive(16'd1, 16'd2);
		tick();

		// zero pool and a full queue
		write_reg(CFG_POOL, 16'd0);
		for (int i = 0; i < QDEPTH + 2; i++) arrive(16'd1, 16'd40);
		tick();
		write_reg(CFG_POOL, 16'd1000);
		tick();

		// fill the table to its limit with long-lived one-unit blocks
		for (int i = 0; i < QDEPTH; i++) arrive(16'd1, 16'hFFFF);
		tick();
		for (int i = 0; i < QDEPTH; i++) arrive(16'd1, 16'hFFFF);
		tick();
		tick();
		write_reg(CFG_POOL, 16'd1000);
		tick();

		// receiver holds off while the sender keeps offering
		settle();
		hold_req = 300;
		for (int i = 0; i < 12; i++) arrive(16'($urandom_range(1, 60)), 16'd3);
		tick();
		for (int i = 0; i < 6; i++) arrive(16'($urandom_range(1, 60)), 16'd3);
		tick();

		write_reg(CFG_POLICY, POL_BEST);
		random_phase(30, 1000);
		write_reg(CFG_POLICY, POL_WORST);
		write_reg(CFG_POOL, 16'd400);
		random_phase(30, 400);
		write_reg(CFG_POLICY, POL_ODD);
		write_reg(CFG_POOL, 16'hFFFF);
		random_phase(25, 65535);
		write_reg(CFG_POLICY, POL_FIRST);
		write_reg(CFG_POOL, 16'd1000);
		idle_en = 0;
		random_phase(40, 1000);

		settle();
		$display("ran %0d ticks: %0d placements and %0d rejects checked",
			sb.ticks, sb.placed, sb.rejected);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else begin
			$display("%0d mismatching words", sb.errors);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
